FILE: design/line_center_steering_controller_top_defines.svh
// ----------------------------------------------------------------------------
// line_center_steering_controller_top_defines
// Assertion macros shared by the steering controller RTL.
// ----------------------------------------------------------------------------
`ifndef LINE_CENTER_STEERING_CONTROLLER_TOP_DEFINES_SVH
`define LINE_CENTER_STEERING_CONTROLLER_TOP_DEFINES_SVH

// same-cycle implication
`define LCSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LCSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/lcsc_pkg.sv
// ----------------------------------------------------------------------------
// lcsc_pkg
// Types and constants of the line center steering controller.
// ----------------------------------------------------------------------------
package lcsc_pkg;

    typedef struct packed {
        logic [9:0] column;
        logic [9:0] row;
        logic [7:0] red;
        logic       frame_end;
    } t_pixel;

    typedef struct packed {
        logic [9:0] left_edge;
        logic [9:0] right_edge;
        logic [7:0] drive_a;
        logic [7:0] drive_b;
    } t_result;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 12;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_DARK_THRESHOLD = 3'd0;
    localparam t_cfg_idx CFG_SCAN_ROW       = 3'd1;
    localparam t_cfg_idx CFG_LEFT_START     = 3'd2;
    localparam t_cfg_idx CFG_BASE_DRIVE     = 3'd3;
    localparam t_cfg_idx CFG_GAIN_Q10       = 3'd4;

    localparam logic [7:0]  RST_DARK_THRESHOLD = 8'd70;
    localparam logic [9:0]  RST_SCAN_ROW       = 10'd470;
    localparam logic [9:0]  RST_LEFT_START     = 10'd5;
    localparam logic [7:0]  RST_BASE_DRIVE     = 8'd130;
    localparam logic [11:0] RST_GAIN_Q10       = 12'd307;

    localparam logic [7:0] DRIVE_MIN = 8'd1;
    localparam logic [7:0] DRIVE_MAX = 8'd254;

endpackage

FILE: design/line_center_steering_controller_top.sv
// ----------------------------------------------------------------------------
// line_center_steering_controller_top
// Tracks dark line edges on one scan row and emits proportional motor drives
// at every frame end.
// ----------------------------------------------------------------------------
// channel   dir  handshake                    payload
// pixel     in   i_in_valid / o_in_stall      i_in_data  (t_pixel)
// result    out  o_out_valid / i_out_stall    o_out_data (t_result)
// config    in   i_cfg_we                     i_cfg_index, i_cfg_data
//
// One pixel per cycle; edge compare and update is done in the accept cycle.
// A frame end request produces a result through three registered
// stages: edge capture, error multiply, add and clamp.
// Synchronous active-low reset clears edges and stage valids and loads config defaults.
// Output stall backs up the stages; input stalls only when the capture
// stage is full and cannot move.
// ----------------------------------------------------------------------------
`include "line_center_steering_controller_top_defines.svh"

module line_center_steering_controller_top
    import lcsc_pkg::*;
#(
    parameter int unsigned WIDTH = 640
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_pixel                i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_result               o_out_data,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [9:0]  WIDTH_COL = 10'(WIDTH);
    localparam logic [10:0] HALF_W    = 11'(WIDTH / 2);

    logic [7:0]  r_dark_threshold;
    logic [9:0]  r_scan_row;
    logic [9:0]  r_left_start;
    logic [7:0]  r_base_drive;
    logic [11:0] r_gain_q10;

    logic [9:0] r_left_col, n_left_col;
    logic       r_left_flag, n_left_flag;
    logic [9:0] r_right_col, n_right_col;

    logic        r_s1_valid;
    logic [9:0]  r_s1_left, r_s1_right;
    logic        r_s2_valid;
    logic [9:0]  r_s2_left, r_s2_right;
    logic signed [23:0] r_s2_prod;
    logic        r_out_valid;
    t_result     r_out_data;

    logic s3_ready, s2_ready, s1_ready, in_acc, hit;
    logic [10:0] w_sum;
    logic signed [10:0] w_err;
    logic signed [23:0] w_err_ext, w_gain_ext, w_prod;
    logic signed [24:0] w_base, w_val_a, w_val_b;

    function automatic logic [7:0] drive_clamp(input logic signed [24:0] v);
        logic signed [14:0] q;
        q = v[24:10];
        if (q < 15'sd1) begin
            return DRIVE_MIN;
        end else if (q > 15'sd254) begin
            return DRIVE_MAX;
        end else begin
            return q[7:0];
        end
    endfunction

    // handshake chain
    assign s3_ready   = !r_out_valid || !i_out_stall;
    assign s2_ready   = !r_s2_valid || s3_ready;
    assign s1_ready   = !r_s1_valid || s2_ready;
    assign o_in_stall = !s1_ready;
    assign in_acc     = i_in_valid && s1_ready;

    // edge update
    always_comb begin
        hit = (i_in_data.row == r_scan_row) && (i_in_data.red < r_dark_threshold)
              && (i_in_data.column < WIDTH_COL);
        n_left_col  = r_left_col;
        n_left_flag = r_left_flag;
        n_right_col = r_right_col;
        if (hit && (i_in_data.column >= r_left_start)
                && (!r_left_flag || (i_in_data.column < r_left_col))) begin
            n_left_col  = i_in_data.column;
            n_left_flag = 1'b1;
        end
        if (hit && (i_in_data.column != 10'd0) && (i_in_data.column > r_right_col)) begin
            n_right_col = i_in_data.column;
        end
    end

    // error and gain
    always_comb begin
        w_sum      = {1'b0, r_s1_left} + {1'b0, r_s1_right};
        w_err      = $signed({1'b0, w_sum[10:1]}) - $signed(HALF_W);
        w_err_ext  = 24'(w_err);
        w_gain_ext = $signed({12'd0, r_gain_q10});
        w_prod     = w_err_ext * w_gain_ext;
        w_base     = $signed({7'd0, r_base_drive, 10'd0});
        w_val_a    = w_base + 25'(r_s2_prod);
        w_val_b    = w_base - 25'(r_s2_prod);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dark_threshold <= RST_DARK_THRESHOLD;
            r_scan_row       <= RST_SCAN_ROW;
            r_left_start     <= RST_LEFT_START;
            r_base_drive     <= RST_BASE_DRIVE;
            r_gain_q10       <= RST_GAIN_Q10;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DARK_THRESHOLD: r_dark_threshold <= i_cfg_data[7:0];
                CFG_SCAN_ROW:       r_scan_row       <= i_cfg_data[9:0];
                CFG_LEFT_START:     r_left_start     <= i_cfg_data[9:0];
                CFG_BASE_DRIVE:     r_base_drive     <= i_cfg_data[7:0];
                CFG_GAIN_Q10:       r_gain_q10       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_col  <= WIDTH_COL;
            r_left_flag <= 1'b0;
            r_right_col <= 10'd0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                if (i_in_data.frame_end) begin
                    r_left_col  <= WIDTH_COL;
                    r_left_flag <= 1'b0;
                    r_right_col <= 10'd0;
                end else begin
                    r_left_col  <= n_left_col;
                    r_left_flag <= n_left_flag;
                    r_right_col <= n_right_col;
                end
            end
            if (s1_ready) begin
                r_s1_valid <= in_acc && i_in_data.frame_end;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
            if (s3_ready) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && in_acc && i_in_data.frame_end) begin
            r_s1_left  <= n_left_col;
            r_s1_right <= n_right_col;
        end
        if (s2_ready && r_s1_valid) begin
            r_s2_left  <= r_s1_left;
            r_s2_right <= r_s1_right;
            r_s2_prod  <= w_prod;
        end
        if (s3_ready && r_s2_valid) begin
            r_out_data.left_edge  <= r_s2_left;
            r_out_data.right_edge <= r_s2_right;
            r_out_data.drive_a    <= drive_clamp(w_val_a);
            r_out_data.drive_b    <= drive_clamp(w_val_b);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `LCSC_ASSERT_NEXT(a_clear_on_frame_end, in_acc && i_in_data.frame_end,
        r_left_col == WIDTH_COL && !r_left_flag && r_right_col == 10'd0,
        "edge state not cleared after frame end")
    `LCSC_ASSERT_NOW(a_flag_col, !r_left_flag, r_left_col == WIDTH_COL,
        "left edge moved without flag")
    `LCSC_ASSERT_NOW(a_edges_in_image, 1'b1,
        r_left_col <= WIDTH_COL && r_right_col < WIDTH_COL,
        "edge state outside image")
    `LCSC_ASSERT_NOW(a_drive_range, r_out_valid,
        r_out_data.drive_a >= DRIVE_MIN && r_out_data.drive_a <= DRIVE_MAX &&
        r_out_data.drive_b >= DRIVE_MIN && r_out_data.drive_b <= DRIVE_MAX,
        "drive out of range")

endmodule

FILE: bench/line_center_steering_controller_top_test.sv
// ----------------------------------------------------------------------------
// line_center_steering_controller_top_test
// Feeds pixel requests on several register settings, predicts the edges and
// clamped motor drives of every frame end, and checks each result in order
// while the input idles and the output stalls at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_center_steering_controller_top_test
    import lcsc_pkg::*;
();

    localparam int PIX_WIDTH    = 640;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 200;
    localparam int NUM_PHASES   = 15;

    class steering_scoreboard;
        logic [7:0]  thr;
        logic [9:0]  row_sel;
        logic [9:0]  lstart;
        logic [7:0]  base;
        logic [11:0] gain;
        logic [9:0]  left_col;
        bit          left_hit;
        logic [9:0]  right_col;
        t_result     expected_drives[$];
        int unsigned mismatches;
        int unsigned pixels_seen;
        int unsigned results_seen;

        function new();
            thr          = RST_DARK_THRESHOLD;
            row_sel      = RST_SCAN_ROW;
            lstart       = RST_LEFT_START;
            base         = RST_BASE_DRIVE;
            gain         = RST_GAIN_Q10;
            mismatches   = 0;
            pixels_seen  = 0;
            results_seen = 0;
            clear_edges();
        endfunction

        function void clear_edges();
            left_col  = 10'(PIX_WIDTH);
            left_hit  = 1'b0;
            right_col = '0;
        endfunction

        function int pending();
            return expected_drives.size();
        endfunction

        function void note_config(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_DARK_THRESHOLD: thr     = val[7:0];
                CFG_SCAN_ROW:       row_sel = val[9:0];
                CFG_LEFT_START:     lstart  = val[9:0];
                CFG_BASE_DRIVE:     base    = val[7:0];
                CFG_GAIN_Q10:       gain    = val[11:0];
                default: ;
            endcase
        endfunction

        // floor(v / 1024) limited to the drive range
        function logic [7:0] clamp_drive(longint v);
            longint q;
            if (v < 1024) return DRIVE_MIN;
            q = v / 1024;
            if (q > longint'(DRIVE_MAX)) return DRIVE_MAX;
            return q[7:0];
        endfunction

        function void note_pixel(t_pixel px);
            int      lc;
            int      rc;
            longint  err;
            longint  term;
            longint  base_q;
            t_result res;
            pixels_seen++;
            if (px.row == row_sel && px.red < thr && int'(px.column) < PIX_WIDTH) begin
                if (px.column >= lstart && (!left_hit || px.column < left_col)) begin
                    left_col = px.column;
                    left_hit = 1'b1;
                end
                if (px.column >= 10'd1 && px.column > right_col) right_col = px.column;
            end
            if (px.frame_end) begin
                lc     = left_col;
                rc     = right_col;
                err    = longint'((lc + rc) / 2) - longint'(PIX_WIDTH / 2);
                term   = err * longint'(int'(gain));
                base_q = longint'(int'(base)) * 1024;
                res.left_edge  = left_col;
                res.right_edge = right_col;
                res.drive_a    = clamp_drive(base_q + term);
                res.drive_b    = clamp_drive(base_q - term);
                expected_drives.push_back(res);
                clear_edges();
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            results_seen++;
            if (expected_drives.size() == 0) begin
                $error("steering result with no frame end request pending");
                mismatches++;
                return;
            end
            want = expected_drives.pop_front();
            if (got.left_edge !== want.left_edge) begin
                $error("left_edge: expected %0d, got %0d", want.left_edge, got.left_edge);
                mismatches++;
            end
            if (got.right_edge !== want.right_edge) begin
                $error("right_edge: expected %0d, got %0d", want.right_edge, got.right_edge);
                mismatches++;
            end
            if (got.drive_a !== want.drive_a) begin
                $error("drive_a: expected %0d, got %0d", want.drive_a, got.drive_a);
                mismatches++;
            end
            if (got.drive_b !== want.drive_b) begin
                $error("drive_b: expected %0d, got %0d", want.drive_b, got.drive_b);
                mismatches++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_pixel                i_in_data;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_result               o_out_data;
    logic                  i_cfg_we;
    t_cfg_idx              i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    steering_scoreboard sb = new();
    bit gaps_on;
    int hold_seq;
    int settings_used;

    line_center_steering_controller_top #(
        .WIDTH(PIX_WIDTH)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_data);
    end

    initial begin : out_stall_gen
        int run;
        int quiet;
        int hold_left;
        int hold_seen;
        int pick;
        run         = 0;
        quiet       = 0;
        hold_left   = 0;
        hold_seen   = 0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_seen != hold_seq) begin
                hold_seen = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (run > 0) begin
                run--;
                i_out_stall <= 1'b1;
            end else if (quiet > 0) begin
                quiet--;
                i_out_stall <= 1'b0;
            end else begin
                pick = $urandom_range(0, 999);
                if (pick < 5) begin
                    quiet = $urandom_range(50, 150);
                    i_out_stall <= 1'b0;
                end else if (pick < 750) begin
                    i_out_stall <= 1'b0;
                end else if (pick < 960) begin
                    run = $urandom_range(0, 2);
                    i_out_stall <= 1'b1;
                end else begin
                    run = $urandom_range(10, 40);
                    i_out_stall <= 1'b1;
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int idle_gap();
        int pick;
        if (!gaps_on) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 65) return 0;
        if (pick < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_pixel make_pixel(int col, int row, int red, bit last);
        t_pixel px;
        px.column    = 10'(col);
        px.row       = 10'(row);
        px.red       = 8'(red);
        px.frame_end = last;
        return px;
    endfunction

    function automatic t_pixel random_pixel(bit last);
        t_pixel px;
        int     red;
        px.column = ($urandom_range(0, 99) < 80) ? 10'($urandom_range(0, PIX_WIDTH - 1))
                                                 : 10'($urandom_range(0, 1023));
        px.row    = ($urandom_range(0, 99) < 75) ? sb.row_sel : 10'($urandom_range(0, 1023));
        if ($urandom_range(0, 1) == 0) begin
            red = $urandom_range(0, 255);
        end else begin
            red = int'(sb.thr) + int'($urandom_range(0, 4)) - 2;
            if (red < 0) red = 0;
            if (red > 255) red = 255;
        end
        px.red       = 8'(red);
        px.frame_end = last;
        return px;
    endfunction

    task automatic send_pixel(input t_pixel px);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= px;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_pixel(px);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        sb.note_config(idx, val);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // upper data bits beyond each register's width are noise
    task automatic apply_config(input int thr, input int row, input int lst, input int base,
                                input int gain, input int ph);
        cfg_write(CFG_DARK_THRESHOLD, {4'($urandom), 8'(thr)});
        cfg_write(CFG_SCAN_ROW,       {2'($urandom), 10'(row)});
        cfg_write(CFG_LEFT_START,     {2'($urandom), 10'(lst)});
        cfg_write(CFG_BASE_DRIVE,     {4'($urandom), 8'(base)});
        cfg_write(CFG_GAIN_Q10,       12'(gain));
        cfg_write(t_cfg_idx'(5 + ph % 3), 12'($urandom));
        settings_used++;
    endtask

    task automatic send_frame(input int len);
        for (int i = 0; i < len; i++) send_pixel(random_pixel(i == len - 1));
    endtask

    initial begin
        t_pixel directed_px[$];
        int     len;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        gaps_on       = 1'b1;
        hold_seq      = 0;
        settings_used = 1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: empty frame, boundaries, reversed order, end pixel counted
        directed_px.push_back(make_pixel(0, 0, 255, 1'b1));
        directed_px.push_back(make_pixel(0, 470, 0, 1'b0));
        directed_px.push_back(make_pixel(4, 470, 69, 1'b0));
        directed_px.push_back(make_pixel(5, 470, 70, 1'b0));
        directed_px.push_back(make_pixel(5, 470, 69, 1'b0));
        directed_px.push_back(make_pixel(639, 470, 0, 1'b0));
        directed_px.push_back(make_pixel(640, 470, 0, 1'b0));
        directed_px.push_back(make_pixel(1023, 470, 0, 1'b1));
        directed_px.push_back(make_pixel(600, 470, 10, 1'b0));
        directed_px.push_back(make_pixel(300, 470, 10, 1'b0));
        directed_px.push_back(make_pixel(450, 471, 0, 1'b0));
        directed_px.push_back(make_pixel(200, 1023, 0, 1'b0));
        directed_px.push_back(make_pixel(1, 470, 255, 1'b0));
        directed_px.push_back(make_pixel(1, 470, 0, 1'b1));
        directed_px.push_back(make_pixel(10, 470, 0, 1'b0));
        directed_px.push_back(make_pixel(12, 470, 0, 1'b1));
        directed_px.push_back(make_pixel(639, 470, 0, 1'b1));
        directed_px.push_back(make_pixel(1, 470, 0, 1'b1));
        directed_px.push_back(make_pixel(1022, 470, 0, 1'b0));
        directed_px.push_back(make_pixel(3, 470, 0, 1'b1));
        foreach (directed_px[i]) send_pixel(directed_px[i]);
        wait_idle();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: apply_config(255, 0, 0, 255, 4095, ph);
                1: apply_config(0, 1023, 1023, 0, 0, ph);
                2: apply_config(128, 512, 700, 1, 1, ph);
                3: apply_config(200, 470, 639, 254, 2048, ph);
                4: apply_config(70, 470, 5, 130, 307, ph);
                default: begin
                    apply_config($urandom_range(0, 255), $urandom_range(0, 1023),
                                 ($urandom_range(0, 99) < 80) ? $urandom_range(0, PIX_WIDTH - 1)
                                                              : $urandom_range(0, 1023),
                                 $urandom_range(0, 255), $urandom_range(0, 4095), ph);
                end
            endcase
            gaps_on = (ph % 4 != 2);
            for (int f = 0; f < 8; f++) begin
                len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(4, 24);
                send_frame(len);
            end
            // output held off while frame ends keep coming: pipeline backs up
            if (ph == 7) begin
                gaps_on = 1'b0;
                hold_seq++;
                for (int i = 0; i < 40; i++) send_pixel(random_pixel(1'b1));
            end
            wait_idle();
        end

        $display("Sent %0d pixel requests under %0d register settings, checked %0d results.",
                 sb.pixels_seen, settings_used, sb.results_seen);
        if (sb.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
